// File: sv/sia_pkg.sv
// Shared types, operation codes and constants for the script integer ALU.
package sia_pkg;

    localparam int ACTION_W = 5;

    localparam logic [ACTION_W-1:0] OP_DIV  = 5'd6;
    localparam logic [ACTION_W-1:0] OP_MOD  = 5'd7;
    localparam logic [ACTION_W-1:0] OP_ADD  = 5'd8;
    localparam logic [ACTION_W-1:0] OP_SUB  = 5'd9;
    localparam logic [ACTION_W-1:0] OP_XOR  = 5'd10;
    localparam logic [ACTION_W-1:0] OP_OR   = 5'd11;
    localparam logic [ACTION_W-1:0] OP_AND  = 5'd12;
    localparam logic [ACTION_W-1:0] OP_EQ   = 5'd13;
    localparam logic [ACTION_W-1:0] OP_LOR  = 5'd14;
    localparam logic [ACTION_W-1:0] OP_GT   = 5'd15;
    localparam logic [ACTION_W-1:0] OP_LT   = 5'd16;
    localparam logic [ACTION_W-1:0] OP_GE   = 5'd17;
    localparam logic [ACTION_W-1:0] OP_LE   = 5'd18;
    localparam logic [ACTION_W-1:0] OP_MUL  = 5'd19;
    localparam logic [ACTION_W-1:0] OP_NE   = 5'd20;
    localparam logic [ACTION_W-1:0] OP_LAND = 5'd21;
    localparam logic [ACTION_W-1:0] OP_SRA  = 5'd22;
    localparam logic [ACTION_W-1:0] OP_SHL  = 5'd23;

    // quotient value for a zero divisor, truncated to the data width
    localparam logic [63:0] DIV_ZERO_VALUE = 64'h0000_0000_0FFF_FFFF;

    localparam int FIELD_W = 32;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV,
        KIND_MOD
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  neg_q;
        logic  neg_r;
        logic  b_zero;
        logic  unknown;
    } ctrl_t;

    // 2^j mod w without a divider; elaboration only
    function automatic int pow2_mod(input int j, input int w);
        int v;
        v = 1;
        for (int k = 0; k < j; k++) begin
            v = v * 2;
            if (v >= w) begin
                v = v - w;
            end
        end
        return v;
    endfunction

endpackage

// File: sv/script_integer_alu_top.sv
// Top level of the script integer ALU: front stage, cell chain, output register.
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+-------------------
//  s_axis   | in  | [31:0] left_operand, [63:32] right_op.  | [4:0] action
//  m_axis   | out | [31:0] result                           | [0] unknown_action
//
// The pipe has one front stage, one cell per quotient or multiplier bit and
// one output register. One beat enters every cycle while the pipe advances.
// The whole pipe advances together; it holds only while the output beat
// waits and m_axis_tready is low. rst_n clears all valid bits asynchronously.
module script_integer_alu_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] left_operand, [63:32] right_operand
    input  logic [4:0]  s_axis_tuser,   // [4:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result
    output logic [0:0]  m_axis_tuser    // [0] unknown_action
);
    import sia_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic          en;
    ctrl_t         ctrl [0:DW];
    logic [DW-1:0] p [0:DW];
    logic [DW-1:0] r [0:DW];
    logic [DW-1:0] d [0:DW];
    logic [DW-1:0] m [0:DW];
    logic [DW-1:0] simple [0:DW];

    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic          out_unknown_reg;
    logic [DW-1:0] res_next;
    ctrl_t         last;

    // advance unless a finished beat is blocked at the output
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    sia_front #(.DW(DW)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_axis_tvalid),
        .action        (s_axis_tuser),
        .left_operand  (s_axis_tdata[31:0]),
        .right_operand (s_axis_tdata[63:32]),
        .ctrl          (ctrl[0]),
        .p             (p[0]),
        .r             (r[0]),
        .d             (d[0]),
        .m             (m[0]),
        .simple        (simple[0])
    );

    // one cell per bit: restoring divide step or shift-add multiply step
    for (genvar i = 0; i < DW; i++) begin : g_cell
        sia_cell #(.DW(DW)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .ctrl_in    (ctrl[i]),
            .p_in       (p[i]),
            .r_in       (r[i]),
            .d_in       (d[i]),
            .m_in       (m[i]),
            .simple_in  (simple[i]),
            .ctrl_out   (ctrl[i+1]),
            .p_out      (p[i+1]),
            .r_out      (r[i+1]),
            .d_out      (d[i+1]),
            .m_out      (m[i+1]),
            .simple_out (simple[i+1])
        );
    end

    assign last = ctrl[DW];

    // result select per kind, sign fix-up and zero-divisor cases
    always_comb
    begin
        case (last.kind)
            KIND_MUL: res_next = p[DW];
            KIND_DIV:
            begin
                if (last.b_zero) begin
                    res_next = DW'(DIV_ZERO_VALUE);
                end else if (last.neg_q) begin
                    res_next = ~p[DW] + 1'b1;
                end else begin
                    res_next = p[DW];
                end
            end
            KIND_MOD:
            begin
                if (last.b_zero) begin
                    res_next = '0;
                end else if (last.neg_r) begin
                    res_next = ~r[DW] + 1'b1;
                end else begin
                    res_next = r[DW];
                end
            end
            default: res_next = simple[DW];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_data_reg    <= 32'(signed'(res_next));
            out_unknown_reg <= last.unknown;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_unknown_reg;
endmodule

// File: sv/sia_front.sv
// Operand decode, the operations that need no cell chain, and setup of the cell chain.
module sia_front #(
    parameter int DW = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [sia_pkg::ACTION_W-1:0]       action,
    input  logic signed [sia_pkg::FIELD_W-1:0] left_operand,
    input  logic signed [sia_pkg::FIELD_W-1:0] right_operand,
    output sia_pkg::ctrl_t                     ctrl,
    output logic [DW-1:0]                      p,
    output logic [DW-1:0]                      r,
    output logic [DW-1:0]                      d,
    output logic [DW-1:0]                      m,
    output logic [DW-1:0]                      simple
);
    import sia_pkg::*;

    localparam int SH_W  = $clog2(DW);
    localparam int SUM_W = 12;
    localparam int RSH   = 20;
    localparam int RECIP = ((1 << RSH) + DW - 1) / DW;

    logic signed [DW-1:0] a, b;
    logic [DW-1:0]        a_mag, b_mag;
    logic [SUM_W-1:0]     fold;
    logic [SUM_W+RSH-1:0] prod;
    logic [SUM_W-1:0]     quo;
    logic [SUM_W-1:0]     rem;
    logic [SH_W-1:0]      sh;
    logic                 lt_ab, lt_ba;
    ctrl_t                ctrl_next;
    logic [DW-1:0]        p_next, r_next, d_next, m_next, simple_next;
    ctrl_t                ctrl_reg;
    logic [DW-1:0]        p_reg, r_reg, d_reg, m_reg, simple_reg;

    assign a = DW'(left_operand);
    assign b = DW'(right_operand);
    assign a_mag = a[DW-1] ? (~a + 1'b1) : a;
    assign b_mag = b[DW-1] ? (~b + 1'b1) : b;
    assign lt_ab = a < b;
    assign lt_ba = b < a;

    // shift count: b mod DW via folded residues and a reciprocal multiply
    always_comb
    begin
        fold = '0;
        for (int j = 0; j < DW; j++) begin
            if (b[j]) begin
                fold = fold + SUM_W'(pow2_mod(j, DW));
            end
        end
    end
    assign prod = (SUM_W+RSH)'(fold) * (SUM_W+RSH)'(RECIP);
    assign quo  = prod[SUM_W+RSH-1:RSH];
    assign rem  = fold - SUM_W'(quo * SUM_W'(DW));
    assign sh   = rem[SH_W-1:0];

    always_comb
    begin
        ctrl_next.valid   = in_valid;
        ctrl_next.kind    = KIND_SIMPLE;
        ctrl_next.neg_q   = a[DW-1] ^ b[DW-1];
        ctrl_next.neg_r   = a[DW-1];
        ctrl_next.b_zero  = (b == '0);
        ctrl_next.unknown = 1'b0;
        p_next      = '0;
        r_next      = '0;
        d_next      = b_mag;
        m_next      = b;
        simple_next = a;
        case (action)
            OP_DIV:
            begin
                ctrl_next.kind = KIND_DIV;
                p_next = a_mag;
            end
            OP_MOD:
            begin
                ctrl_next.kind = KIND_MOD;
                p_next = a_mag;
            end
            OP_MUL:
            begin
                ctrl_next.kind = KIND_MUL;
                d_next = a;
            end
            OP_ADD:  simple_next = a + b;
            OP_SUB:  simple_next = a - b;
            OP_XOR:  simple_next = a ^ b;
            OP_OR:   simple_next = a | b;
            OP_AND:  simple_next = a & b;
            OP_EQ:   simple_next = DW'(a == b);
            OP_NE:   simple_next = DW'(a != b);
            OP_LOR:  simple_next = DW'((a != '0) || (b != '0));
            OP_LAND: simple_next = DW'((a != '0) && (b != '0));
            OP_GT:   simple_next = DW'(lt_ba);
            OP_LT:   simple_next = DW'(lt_ab);
            OP_GE:   simple_next = DW'(!lt_ab);
            OP_LE:   simple_next = DW'(!lt_ba);
            OP_SRA:  simple_next = a >>> sh;
            OP_SHL:  simple_next = a << sh;
            default: ctrl_next.unknown = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            p_reg      <= p_next;
            r_reg      <= r_next;
            d_reg      <= d_next;
            m_reg      <= m_next;
            simple_reg <= simple_next;
        end
    end

    assign ctrl   = ctrl_reg;
    assign p      = p_reg;
    assign r      = r_reg;
    assign d      = d_reg;
    assign m      = m_reg;
    assign simple = simple_reg;
endmodule

// File: sv/sia_cell.sv
// One cell of the chain: a restoring-divide step or a shift-add multiply step.
module sia_cell #(
    parameter int DW = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  sia_pkg::ctrl_t ctrl_in,
    input  logic [DW-1:0]  p_in,
    input  logic [DW-1:0]  r_in,
    input  logic [DW-1:0]  d_in,
    input  logic [DW-1:0]  m_in,
    input  logic [DW-1:0]  simple_in,
    output sia_pkg::ctrl_t ctrl_out,
    output logic [DW-1:0]  p_out,
    output logic [DW-1:0]  r_out,
    output logic [DW-1:0]  d_out,
    output logic [DW-1:0]  m_out,
    output logic [DW-1:0]  simple_out
);
    import sia_pkg::*;

    logic [DW:0]   rs, trial;
    logic [DW-1:0] p_next, r_next, d_next, m_next;
    ctrl_t         ctrl_reg;
    logic [DW-1:0] p_reg, r_reg, d_reg, m_reg, simple_reg;

    assign rs    = {r_in, p_in[DW-1]};
    assign trial = rs - {1'b0, d_in};

    always_comb
    begin
        p_next = p_in;
        r_next = r_in;
        d_next = d_in;
        m_next = m_in;
        case (ctrl_in.kind)
            KIND_MUL:
            begin
                p_next = p_in + (m_in[0] ? d_in : '0);
                d_next = d_in << 1;
                m_next = m_in >> 1;
            end
            KIND_DIV, KIND_MOD:
            begin
                if (!trial[DW]) begin
                    r_next = trial[DW-1:0];
                    p_next = {p_in[DW-2:0], 1'b1};
                end else begin
                    r_next = rs[DW-1:0];
                    p_next = {p_in[DW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            p_reg      <= p_next;
            r_reg      <= r_next;
            d_reg      <= d_next;
            m_reg      <= m_next;
            simple_reg <= simple_in;
        end
    end

    assign ctrl_out   = ctrl_reg;
    assign p_out      = p_reg;
    assign r_out      = r_reg;
    assign d_out      = d_reg;
    assign m_out      = m_reg;
    assign simple_out = simple_reg;
endmodule

// File: sim/script_integer_alu_top_test.sv
// Self-checking stream testbench for the script integer ALU: directed corners, then random traffic.
module script_integer_alu_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sia_pkg::*;

    localparam int DW = 32;
    localparam int N_RANDOM = 800;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] left_operand, [63:32] right_operand
    logic [4:0]  s_axis_tuser;   // [4:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] result
    logic [0:0]  m_axis_tuser;   // [0] unknown_action

    script_integer_alu_top #(.DATA_WIDTH(DW)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    typedef struct packed {
        logic [31:0] value;
        logic        unknown;
    } alu_out_t;

    // Expected-result store plus the ALU predictor.
    class alu_scoreboard;
        alu_out_t pending[$];
        int       mismatches;

        function alu_out_t compute(logic [4:0] op, logic signed [31:0] a,
                                   logic signed [31:0] b);
            alu_out_t o;
            logic [4:0] sh;
            o.unknown = 1'b0;
            sh = b[4:0];   // shift count mod 32
            case (op)
                OP_DIV:
                    if (b == 0) o.value = DIV_ZERO_VALUE[31:0];
                    else if (a == 32'sh8000_0000 && b == -1) o.value = a;  // wraps
                    else o.value = a / b;   // truncates toward zero
                OP_MOD:
                    if (b == 0) o.value = '0;
                    else if (a == 32'sh8000_0000 && b == -1) o.value = '0;
                    else o.value = a % b;   // sign of dividend
                OP_ADD:  o.value = a + b;
                OP_SUB:  o.value = a - b;
                OP_XOR:  o.value = a ^ b;
                OP_OR:   o.value = a | b;
                OP_AND:  o.value = a & b;
                OP_EQ:   o.value = {31'b0, a == b};
                OP_LOR:  o.value = {31'b0, (a != 0) || (b != 0)};
                OP_GT:   o.value = {31'b0, a > b};
                OP_LT:   o.value = {31'b0, a < b};
                OP_GE:   o.value = {31'b0, a >= b};
                OP_LE:   o.value = {31'b0, a <= b};
                OP_MUL:  o.value = a * b;
                OP_NE:   o.value = {31'b0, a != b};
                OP_LAND: o.value = {31'b0, (a != 0) && (b != 0)};
                OP_SRA:  o.value = a >>> sh;
                OP_SHL:  o.value = a << sh;
                default:
                begin
                    o.value   = a;
                    o.unknown = 1'b1;
                end
            endcase
            return o;
        endfunction

        function void note_operation(logic [4:0] op, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute(op, a, b));
        endfunction

        function void check_result(logic [31:0] value, logic unknown);
            alu_out_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h unknown=%b", value, unknown);
                return;
            end
            e = pending.pop_front();
            if (e.value !== value || e.unknown !== unknown)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%b, got %h/%b",
                             e.value, e.unknown, value, unknown);
            end
        endfunction
    endclass

    alu_scoreboard board;
    int unsigned   idle_cycles;
    bit            stim_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor both sides on the rising edge; watchdog counts cycles with no beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_operation(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser[0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: stalls in runs of its own, with occasional always-ready stretches.
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60))
            begin
                @(negedge clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    // Present one beat at the falling edge and hold it until accepted.
    task automatic send_op(logic [4:0] op, logic [31:0] a, logic [31:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_input(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'(int'($urandom_range(0, 4)));
            4:       return -32'(int'($urandom_range(1, 40)));
            5:       return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [4:0] op;
        int         left;
        board         = new();
        idle_cycles   = 0;
        stim_done     = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero divisors, INT_MIN / -1, rounding signs, shift wrap, unknown codes.
        send_op(OP_DIV, 32'd100, 32'd0);
        send_op(OP_MOD, 32'd100, 32'd0);
        send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_op(OP_MOD, 32'h8000_0000, 32'hffff_ffff);
        send_op(OP_DIV, -32'd7, 32'd2);
        send_op(OP_MOD, -32'd7, 32'd2);
        send_op(OP_MOD, 32'd7, -32'd2);
        send_op(OP_ADD, 32'h7fff_ffff, 32'd1);
        send_op(OP_SUB, 32'h8000_0000, 32'd1);
        send_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_op(OP_XOR, 32'hffff_ffff, 32'h0000_0000);
        send_op(OP_OR,  32'hffff_ffff, 32'hffff_ffff);
        send_op(OP_AND, 32'hffff_ffff, 32'hffff_ffff);
        send_op(OP_EQ,  32'd5, 32'd5);
        send_op(OP_NE,  32'd5, 32'd5);
        send_op(OP_LOR, 32'd0, 32'd0);
        send_op(OP_LAND, 32'd3, 32'h8000_0000);
        send_op(OP_GT,  32'h8000_0000, 32'h7fff_ffff);
        send_op(OP_LT,  32'h8000_0000, 32'h7fff_ffff);
        send_op(OP_GE,  32'd4, 32'd4);
        send_op(OP_LE,  32'hffff_ffff, 32'd0);
        send_op(OP_SRA, 32'h8000_0000, 32'd33);
        send_op(OP_SHL, 32'h0000_0001, 32'hffff_ffff);
        send_op(5'd0,   32'h1234_5678, 32'd0);
        send_op(5'd31,  32'hffff_ffff, 32'hffff_ffff);

        // Random bursts; mostly known codes, some unknown ones.
        left = N_RANDOM;
        while (left > 0)
        begin
            repeat ($urandom_range(1, 30))
            begin
                if (left > 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                        op = 5'($urandom_range(0, 31));
                    else
                        op = 5'($urandom_range(OP_DIV, OP_SHL));
                    send_op(op, pick_operand(), pick_operand());
                    left--;
                end
            end
            if ($urandom_range(0, 2) != 0)
                pause_input($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // End of run: drain expectations, then allow the pipe latency to pass.
    initial
    begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (2 * (DW + 2)) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
